FILE: rtl/core/sef_pkg.sv
// Shared types and constants for the scaled EMA filter with change detect.
// No dependencies; used by sef_ctrl, sef_datapath and the top level.
package sef_pkg;

    localparam int RAW_BITS  = 12;
    localparam int VAL_W     = 32;
    localparam int COEF_W    = 17;
    localparam int THR_W     = 31;
    localparam int FRAC_BITS = 16;
    localparam int CFG_IDX_W = 3;

    localparam int SPAN_W = VAL_W + 1;
    localparam int PROD_W = SPAN_W + RAW_BITS + 1;
    localparam int SUM_W  = SPAN_W + 2;
    localparam int MUL_W  = VAL_W + COEF_W + 1;
    localparam int ACC_W  = MUL_W + 1;

    localparam logic [COEF_W-1:0] COEF_ONE   = COEF_W'(1 << FRAC_BITS);
    localparam int                ROUND_HALF = 1 << (FRAC_BITS - 1);

    localparam logic signed [VAL_W-1:0] SCALE_MIN_RST   = '0;
    localparam logic signed [VAL_W-1:0] SCALE_MAX_RST   = VAL_W'(1 << FRAC_BITS);
    localparam logic signed [VAL_W-1:0] FILTER_PREV_RST = VAL_W'(1 << (FRAC_BITS - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_MIN        = 3'd0,
        CFG_SCALE_MAX        = 3'd1,
        CFG_FILTER_COEF      = 3'd2,
        CFG_TRIM_OFFSET      = 3'd3,
        CFG_CHANGE_THRESHOLD = 3'd4
    } t_cfg_idx;

    // Commands from the sequencer to the datapath, one step per bit
    typedef struct packed {
        logic load;
        logic scale;
        logic clamp;
        logic mul_new;
        logic mul_old;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/core/scaled_ema_filter_with_change_detect.sv
// Scaled EMA filter with change detect: one result per 12-bit sample. The result is
// presented in the output register after the sequencer's scale, clamp, two multiply and
// done steps; a new request is taken only once the sequencer is idle again, and a stalled
// output register holds the sequencer in its last step. The sequencer runs scale multiply,
// clamp, then the two filter multiplies one after the other on registered operands,
// and the last step updates filter state and loads the output register. i_cfg_* writes
// are always taken (o_cfg_ready high); write them only while no request is in flight.
// Depends on sef_pkg, sef_ctrl and sef_datapath.
module scaled_ema_filter_with_change_detect (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sef_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sef_pkg::VAL_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [sef_pkg::RAW_BITS-1:0]      i_raw_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [sef_pkg::VAL_W-1:0]  o_filtered_value,
    output logic                              o_changed,
    output logic                              o_toggle_out
);

    sef_pkg::t_cmd  w_cmd;
    sef_pkg::t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    sef_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sef_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_raw_sample     (i_raw_sample),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_filtered_value (o_filtered_value),
        .o_changed        (o_changed),
        .o_toggle_out     (o_toggle_out)
    );

endmodule

FILE: rtl/core/sef_ctrl.sv
// Sequencer for the scaled EMA filter: steps one request through the datapath.
// Depends on sef_pkg (t_cmd, t_stat).
module sef_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  sef_pkg::t_stat i_stat,
    output sef_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SCALE   = 6'b000010,
        S_CLAMP   = 6'b000100,
        S_MUL_NEW = 6'b001000,
        S_MUL_OLD = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCALE;
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_MUL_NEW;
            end
            S_MUL_NEW: begin
                o_cmd.mul_new = 1'b1;
                n_state       = S_MUL_OLD;
            end
            S_MUL_OLD: begin
                o_cmd.mul_old = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCALE))
        else $error("accepted request did not start the scale step");

    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_stat.out_free)
        else $error("result written while output register was busy");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath step commanded");
`endif

endmodule

FILE: rtl/core/sef_datapath.sv
// Datapath of the scaled EMA filter: config registers, scaling, clamp,
// filter multiplies, change detect and the output register. Depends on sef_pkg.
module sef_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [sef_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sef_pkg::VAL_W-1:0]           i_cfg_data,
    input  logic [sef_pkg::RAW_BITS-1:0]        i_raw_sample,
    input  sef_pkg::t_cmd                       i_cmd,
    output sef_pkg::t_stat                      o_stat,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic signed [sef_pkg::VAL_W-1:0]    o_filtered_value,
    output logic                                o_changed,
    output logic                                o_toggle_out
);

    // configuration
    logic signed [sef_pkg::VAL_W-1:0]  r_scale_min;
    logic signed [sef_pkg::VAL_W-1:0]  r_scale_max;
    logic        [sef_pkg::COEF_W-1:0] r_coef;
    logic signed [sef_pkg::VAL_W-1:0]  r_trim;
    logic        [sef_pkg::THR_W-1:0]  r_thr;

    // filter state
    logic signed [sef_pkg::VAL_W-1:0]  r_filter_prev;
    logic signed [sef_pkg::VAL_W-1:0]  r_stable;
    logic                              r_toggle;

    // per-request working registers
    logic        [sef_pkg::RAW_BITS-1:0] r_raw;
    logic signed [sef_pkg::PROD_W-1:0]   r_prod;
    logic signed [sef_pkg::VAL_W-1:0]    r_x;
    logic signed [sef_pkg::MUL_W-1:0]    r_p_new;
    logic signed [sef_pkg::MUL_W-1:0]    r_p_old;
    logic                                r_out_valid;

    logic signed [sef_pkg::SPAN_W-1:0]   w_span;
    logic signed [sef_pkg::RAW_BITS:0]   w_raw_s;
    logic signed [sef_pkg::PROD_W-1:0]   w_prod;
    logic signed [sef_pkg::SPAN_W-1:0]   w_quot;
    logic signed [sef_pkg::SUM_W-1:0]    w_sum;
    logic signed [sef_pkg::VAL_W-1:0]    w_x;
    logic        [sef_pkg::COEF_W-1:0]   w_coef;
    logic        [sef_pkg::COEF_W-1:0]   w_coef_inv;
    logic signed [sef_pkg::ACC_W-1:0]    w_acc;
    logic signed [sef_pkg::VAL_W-1:0]    w_y;
    logic signed [sef_pkg::VAL_W:0]      w_diff;
    logic        [sef_pkg::VAL_W:0]      w_abs;
    logic                                w_changed;

    assign w_span  = sef_pkg::SPAN_W'(r_scale_max) - sef_pkg::SPAN_W'(r_scale_min);
    assign w_raw_s = $signed({1'b0, r_raw});
    assign w_prod  = w_span * w_raw_s;
    // arithmetic shift gives the floor of the quotient
    assign w_quot  = sef_pkg::SPAN_W'(r_prod >>> sef_pkg::RAW_BITS);
    assign w_sum   = sef_pkg::SUM_W'(r_scale_min) + sef_pkg::SUM_W'(w_quot)
                   + sef_pkg::SUM_W'(r_trim);

    // limit to max first, then to min: an inverted range yields min
    always_comb begin
        w_x = sef_pkg::VAL_W'(w_sum);
        if (w_sum > sef_pkg::SUM_W'(r_scale_max)) begin
            w_x = r_scale_max;
        end
        if (w_sum > sef_pkg::SUM_W'(r_scale_max)
            && r_scale_max < r_scale_min) begin
            w_x = r_scale_min;
        end else if (w_sum < sef_pkg::SUM_W'(r_scale_min)) begin
            w_x = r_scale_min;
        end
    end

    assign w_coef     = (r_coef > sef_pkg::COEF_ONE) ? sef_pkg::COEF_ONE : r_coef;
    assign w_coef_inv = sef_pkg::COEF_ONE - w_coef;

    assign w_acc = sef_pkg::ACC_W'(r_p_new) + sef_pkg::ACC_W'(r_p_old)
                 + sef_pkg::ACC_W'(sef_pkg::ROUND_HALF);
    assign w_y   = $signed(w_acc[sef_pkg::FRAC_BITS +: sef_pkg::VAL_W]);

    assign w_diff    = (sef_pkg::VAL_W+1)'(w_y) - (sef_pkg::VAL_W+1)'(r_stable);
    assign w_abs     = w_diff[sef_pkg::VAL_W] ? $unsigned(-w_diff) : $unsigned(w_diff);
    assign w_changed = (w_abs >= {2'b00, r_thr});

    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_min   <= sef_pkg::SCALE_MIN_RST;
            r_scale_max   <= sef_pkg::SCALE_MAX_RST;
            r_coef        <= sef_pkg::COEF_ONE;
            r_trim        <= '0;
            r_thr         <= '0;
            r_filter_prev <= sef_pkg::FILTER_PREV_RST;
            r_stable      <= '0;
            r_toggle      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    sef_pkg::CFG_SCALE_MIN:        r_scale_min <= $signed(i_cfg_data);
                    sef_pkg::CFG_SCALE_MAX:        r_scale_max <= $signed(i_cfg_data);
                    sef_pkg::CFG_FILTER_COEF:      r_coef <= i_cfg_data[sef_pkg::COEF_W-1:0];
                    sef_pkg::CFG_TRIM_OFFSET:      r_trim <= $signed(i_cfg_data);
                    sef_pkg::CFG_CHANGE_THRESHOLD: r_thr <= i_cfg_data[sef_pkg::THR_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.finish) begin
                r_filter_prev <= w_y;
                r_toggle      <= r_toggle ^ !w_changed;
                if (w_changed) begin
                    r_stable <= w_y;
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw <= i_raw_sample;
        end
        if (i_cmd.scale) begin
            r_prod <= w_prod;
        end
        if (i_cmd.clamp) begin
            r_x <= w_x;
        end
        if (i_cmd.mul_new) begin
            r_p_new <= $signed({1'b0, w_coef}) * r_x;
        end
        if (i_cmd.mul_old) begin
            r_p_old <= $signed({1'b0, w_coef_inv}) * r_filter_prev;
        end
        if (i_cmd.finish) begin
            o_filtered_value <= w_y;
            o_changed        <= w_changed;
            o_toggle_out     <= r_toggle ^ !w_changed;
        end
    end

`ifndef SYNTH
    a_clamp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.clamp) && ($past(r_scale_max) >= $past(r_scale_min))
        |-> (r_x >= $past(r_scale_min)) && (r_x <= $past(r_scale_max)))
        else $error("clamped sample outside the scale range");

    a_finish_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> r_out_valid && (o_filtered_value == r_filter_prev)
                         && (o_toggle_out == r_toggle))
        else $error("output register does not match the updated filter state");

    a_toggle_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_toggle == ($past(r_toggle) ^ !o_changed)))
        else $error("toggle bit did not follow the change flag");
`endif

endmodule
